### rtl/core/aes256_ctr_block_cipher_core_defines.svh
// Assertion macros for the AES-256 CTR core
`ifndef AES256_CTR_BLOCK_CIPHER_CORE_DEFINES_SVH
`define AES256_CTR_BLOCK_CIPHER_CORE_DEFINES_SVH

// antecedent holds -> consequent in the same cycle
`define AES_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aes core check failed");

// antecedent holds -> consequent in the next cycle
`define AES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aes core check failed");

`endif

### rtl/core/aes_ctr_pkg.sv
// Shared AES constants, S-box table and round helper functions
package aes_ctr_pkg;

  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam int          NUM_ROUNDS = 14;
  localparam logic [3:0]  LAST_ROUND = 4'd14;

  localparam logic [7:0] REG_KEY0 = 8'd0;
  localparam logic [7:0] REG_KEY1 = 8'd1;
  localparam logic [7:0] REG_KEY2 = 8'd2;
  localparam logic [7:0] REG_KEY3 = 8'd3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col);
    logic [7:0] a0, a1, a2, a3, all;
    a0  = col[31:24];
    a1  = col[23:16];
    a2  = col[15:8];
    a3  = col[7:0];
    all = a0 ^ a1 ^ a2 ^ a3;
    mix_col = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
               a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
  endfunction

endpackage

### rtl/core/aes256_ctr_block_cipher_core.sv
// One AES round per cycle; the last round waits while the prior result is stalled.
// One block at a time: in_stall holds off new input while a block runs through the single
//   shared round unit and the on-the-fly key schedule (4 round-key words per cycle).
// A new input is taken while a finished result still waits in the output register.
// Reset (rst, synchronous): idle, no result pending, key words cleared to zero.
// Round keys are regenerated from the key words for every block; no clearing pass.
`include "aes256_ctr_block_cipher_core_defines.svh"

module aes256_ctr_block_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_hi,
  input  logic [63:0] data_lo,
  input  logic [31:0] seg_id,
  input  logic [31:0] frame_num,
  input  logic [63:0] block_index,
  input  logic [3:0]  first_byte,
  input  logic [3:0]  last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_hi,
  output logic [63:0] result_lo
);
  import aes_ctr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic         state;
  logic [3:0]   rnd;
  logic [7:0]   rcon;
  logic [63:0]  key_word0, key_word1, key_word2, key_word3;
  logic [127:0] st;
  logic [255:0] win;     // round-key words w[4r-4 .. 4r+3], word 0 at the top
  logic [127:0] data;
  logic [15:0]  mask;    // bit 15 is byte 0

  logic         in_acc, last_rnd, finish, hold_done;
  logic [127:0] ctr, sr, mixed, st_next;
  logic [31:0]  t, n0, n1, n2, n3;
  logic [15:0]  mask_next;
  logic [127:0] mask_wide;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state == ST_RUN);
  assign last_rnd  = (rnd == LAST_ROUND);
  assign finish    = (state == ST_RUN) && last_rnd && !(out_valid && out_stall);
  assign hold_done = (state == ST_RUN) && last_rnd && out_valid;

  assign ctr = {seg_id, frame_num, block_index};

  // shared round unit: SubBytes + ShiftRows, MixColumns except in the last round, then AddRoundKey
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        sr[127 - 8 * (4 * c + k) -: 8] = SBOX[st[127 - 8 * (4 * ((c + k) % 4) + k) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32 * c -: 32] = mix_col(sr[127 - 32 * c -: 32]);
    end
    st_next = (last_rnd ? sr : mixed) ^ win[127:0];
  end

  // next four key-schedule words; odd rounds produce a word index divisible by 8
  always_comb begin
    if (rnd[0]) begin
      t = sub_word({win[23:0], win[31:24]}) ^ {rcon, 24'h0};
    end else begin
      t = sub_word(win[31:0]);
    end
    n0 = win[255:224] ^ t;
    n1 = win[223:192] ^ n0;
    n2 = win[191:160] ^ n1;
    n3 = win[159:128] ^ n2;
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask_next[15 - i] = (4'(i) >= first_byte) && (4'(i) <= last_byte);
      mask_wide[127 - 8 * i -: 8] = {8{mask[15 - i]}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0 <= '0;
      key_word1 <= '0;
      key_word2 <= '0;
      key_word3 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0: key_word0 <= cfg_data;
        REG_KEY1: key_word1 <= cfg_data;
        REG_KEY2: key_word2 <= cfg_data;
        REG_KEY3: key_word3 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_RUN;
            rnd   <= 4'd1;
          end
        end
        ST_RUN: begin
          if (finish) begin
            state <= ST_IDLE;
          end else if (!last_rnd) begin
            rnd <= rnd + 4'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win  <= {key_word0, key_word1, key_word2, key_word3};
      st   <= ctr ^ {key_word0, key_word1};
      data <= {data_hi, data_lo};
      mask <= mask_next;
      rcon <= RCON_INIT;
    end else if ((state == ST_RUN) && !last_rnd) begin
      st   <= st_next;
      win  <= {win[127:0], n0, n1, n2, n3};
      if (rnd[0]) begin
        rcon <= xtime(rcon);
      end
    end
    if (finish) begin
      {result_hi, result_lo} <= data ^ (st_next & mask_wide);
    end
  end

  `AES_ASSERT_SAME(a_rnd_range, state == ST_RUN, (rnd >= 4'd1) && (rnd <= LAST_ROUND))
  `AES_ASSERT_NEXT(a_start, in_acc, (state == ST_RUN) && (rnd == 4'd1))
  `AES_ASSERT_NEXT(a_hold_last, hold_done && out_stall, hold_done)

endmodule

### verif/tb_top.sv
// Testbench for the AES-256 CTR block cipher core: predictor, stimulus and result checks
`timescale 1ns / 100ps

module tb_top;
  import aes_ctr_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  logic [31:0] seg_id;
  logic [31:0] frame_num;
  logic [63:0] block_index;
  logic [3:0]  first_byte;
  logic [3:0]  last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] result_hi;
  logic [63:0] result_lo;

  aes256_ctr_block_cipher_core u_top (.*);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic [63:0] key_words [4];
  logic [31:0] sched [60];
  block_t      expected_blocks [$];
  int          mismatches;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] subst(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    logic [7:0]  rc;
    logic [31:0] t;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      sched[2*i]   = key_words[i][63:32];
      sched[2*i+1] = key_words[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = sched[i-1];
      if (i % 8 == 0) begin
        t = subst({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (i % 8 == 4) begin
        t = subst(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
  endfunction

  function automatic block_t ctr_transform(input logic [63:0] dh, input logic [63:0] dl,
                                           input logic [31:0] sg, input logic [31:0] fs,
                                           input logic [63:0] bi, input logic [3:0] fb,
                                           input logic [3:0] lb);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] ctr, dat;
    block_t r;
    ctr = {sg, fs, bi};
    dat = {dh, dl};
    for (int c = 0; c < 16; c++) st[c] = ctr[127-8*c -: 8];
    for (int rnd = 0; rnd <= 14; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 16; c++) st[c] = SBOX[st[c]];
        for (int c = 0; c < 4; c++) begin
          tmp[4*c]   = st[4*c];
          tmp[4*c+1] = st[4*((c+1)%4)+1];
          tmp[4*c+2] = st[4*((c+2)%4)+2];
          tmp[4*c+3] = st[4*((c+3)%4)+3];
        end
        st = tmp;
        if (rnd != 14) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
            st[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
            st[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
            st[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int b = 0; b < 4; b++)
          st[4*c+b] ^= sched[rnd*4+c][31-8*b -: 8];
    end
    for (int c = 0; c < 16; c++)
      if (c >= fb && c <= lb) dat[127-8*c -: 8] ^= st[c];
    r.hi = dat[127:64];
    r.lo = dat[63:0];
    return r;
  endfunction

  // result checker; also drives random output stalls until quiet is set
  always @(posedge clk) begin
    block_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h %h", result_hi, result_lo);
        end else begin
          e = expected_blocks.pop_front();
          if (e.hi !== result_hi || e.lo !== result_lo) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h got %h %h", e.hi, e.lo, result_hi, result_lo);
          end
        end
      end
      out_stall <= (!quiet && $urandom_range(0, 5) == 0) ? 1'b1 : 1'b0;
    end
  end

  task automatic write_key(input logic [7:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx <= REG_KEY3) begin
      key_words[idx] = val;
      expand_schedule();
    end
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // leaves in_valid high after the transaction; drain() drops it, the next call only for its random gap
  task automatic send_block(input logic [63:0] dh, input logic [63:0] dl,
                            input logic [31:0] sg, input logic [31:0] fs,
                            input logic [63:0] bi, input logic [3:0] fb,
                            input logic [3:0] lb);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_hi     <= dh;
    data_lo     <= dl;
    seg_id      <= sg;
    frame_num   <= fs;
    block_index <= bi;
    first_byte  <= fb;
    last_byte   <= lb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_blocks.push_back(ctr_transform(dh, dl, sg, fs, bi, fb, lb));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    write_key(REG_KEY0, 64'h0);
    write_key(REG_KEY1, 64'h0);
    write_key(REG_KEY2, 64'h0);
    write_key(REG_KEY3, 64'h0);
    send_block('0, '0, '0, '0, '0, 4'd0, 4'd15);
    send_block('1, '1, '1, '1, '1, 4'd0, 4'd15);
    send_block('1, '0, 32'h0, 32'h1, 64'h2, 4'd15, 4'd0);  // empty range
    send_block(rand64(), rand64(), '1, '0, '1, 4'd5, 4'd5);
    send_block(rand64(), rand64(), 32'h1, 32'h2, 64'h3, 4'd15, 4'd15);
    send_block(rand64(), rand64(), 32'h1, 32'h2, 64'h3, 4'd3, 4'd12);
    drain();
    write_key(REG_KEY0, 64'hffff_ffff_ffff_ffff);
    write_key(REG_KEY1, 64'hffff_ffff_ffff_ffff);
    write_key(REG_KEY2, 64'hffff_ffff_ffff_ffff);
    write_key(REG_KEY3, 64'hffff_ffff_ffff_ffff);
    send_block('0, '0, '0, '0, '0, 4'd0, 4'd15);
    send_block('1, '1, '1, '1, '1, 4'd0, 4'd7);
    drain();
    // partial key change, then an unknown register index
    write_key(REG_KEY2, 64'h0011_2233_4455_6677);
    write_key(8'd200, rand64());
    send_block(rand64(), rand64(), $urandom, $urandom, rand64(), 4'd0, 4'd15);
    drain();
  endtask

  task automatic test_random(input int n);
    logic [3:0] fb, lb;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        drain();
        for (int k = 0; k < 4; k++) write_key(k[7:0], rand64());
      end
      if (i == 700) quiet = 1'b1;
      fb = 4'($urandom_range(0, 15));
      lb = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) begin
        fb = 4'd0;
        lb = 4'd15;
      end
      send_block(rand64(), rand64(), $urandom, $urandom, rand64(), fb, lb);
      if (i == 350) drain();  // hold off until the pipe is empty
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; out_stall = 1'b0;
    data_hi = '0; data_lo = '0; seg_id = '0; frame_num = '0; block_index = '0;
    first_byte = '0; last_byte = '0;
    mismatches = 0;
    quiet = 1'b0;
    for (int k = 0; k < 4; k++) key_words[k] = '0;
    expand_schedule();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(800);
    drain();
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### aes256_ctr_block_cipher_core.f
+incdir+rtl/core
rtl/core/aes_ctr_pkg.sv
rtl/core/aes256_ctr_block_cipher_core.sv
verif/tb_top.sv
